// ----- src/bsa_pkg.sv -----
// bsa_pkg: shared widths, operation codes and control types of the bounding sphere block
// no dependencies; imported by the interfaces, bsa_alu and the top level
`default_nettype none

package bsa_pkg;

  localparam int unsigned CoordW = 31;
  localparam int unsigned RadW   = 30;
  localparam int unsigned SizeW  = 32;
  localparam int unsigned DiffW  = 32;
  localparam int unsigned AluW   = 66;
  localparam int unsigned DenW   = 35;
  localparam int unsigned Iters  = 32;
  localparam int unsigned CntW   = $clog2(Iters);

  localparam logic [1:0] OP_POINT  = 2'd0;
  localparam logic [1:0] OP_SPHERE = 2'd1;
  localparam logic [1:0] OP_BOX    = 2'd2;
  localparam logic [1:0] OP_RESET  = 2'd3;

  typedef enum logic [1:0] {
    ALU_MUL,
    ALU_DIV,
    ALU_SQRT
  } alu_cmd_e;

  typedef struct packed {
    logic     start;
    alu_cmd_e cmd;
  } alu_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_sts_t;

endpackage

`default_nettype wire

// ----- src/bsa_in_if.sv -----
// bsa_in_if: input channel, valid/ready handshake with the primitive fields
// depends on bsa_pkg for the field widths
`default_nettype none

interface bsa_in_if;
  import bsa_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [1:0]               op;
  logic signed [CoordW-1:0] pos_x;
  logic signed [CoordW-1:0] pos_y;
  logic signed [CoordW-1:0] pos_z;
  logic [RadW-1:0]          sphere_radius;
  logic signed [CoordW-1:0] box_max_x;
  logic signed [CoordW-1:0] box_max_y;
  logic signed [CoordW-1:0] box_max_z;

  modport source (output valid, op, pos_x, pos_y, pos_z, sphere_radius,
                  box_max_x, box_max_y, box_max_z, input ready);
  modport sink   (input valid, op, pos_x, pos_y, pos_z, sphere_radius,
                  box_max_x, box_max_y, box_max_z, output ready);
endinterface

`default_nettype wire

// ----- src/bsa_out_if.sv -----
// bsa_out_if: result channel, valid/ready handshake with the sphere fields
// depends on bsa_pkg for the field widths
`default_nettype none

interface bsa_out_if;
  import bsa_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] center_x;
  logic signed [CoordW-1:0] center_y;
  logic signed [CoordW-1:0] center_z;
  logic [SizeW-1:0]         sphere_size;
  logic                     is_valid;

  modport source (output valid, center_x, center_y, center_z, sphere_size, is_valid,
                  input ready);
  modport sink   (input valid, center_x, center_y, center_z, sphere_size, is_valid,
                  output ready);
endinterface

`default_nettype wire

// ----- src/bsa_alu.sv -----
// bsa_alu: shared bit-serial unit, shift-add multiply, restoring divide, digit square root
// depends on bsa_pkg; every command takes Iters steps, one multiplier, quotient or root bit per step
`default_nettype none

module bsa_alu import bsa_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire alu_ctl_t        ctl_i,
  input  wire logic [AluW-1:0] a_i,
  input  wire logic [DenW-1:0] b_i,
  output alu_sts_t             sts_o,
  output logic [AluW-1:0]      res_o
);

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  alu_cmd_e        cmd_q;

  logic [AluW-1:0]   acc_q, acc_d;
  logic [AluW-1:0]   x_q, x_d;
  logic [Iters-1:0]  y_q, y_d;
  logic [DenW-1:0]   den_q;
  logic [DenW:0]     rem_q, rem_d;
  logic [Iters-1:0]  res_q, res_d;
  logic [DenW:0]     r2;
  logic [DenW:0]     trial;

  always_comb begin
    acc_d = acc_q;
    x_d   = x_q;
    y_d   = y_q;
    rem_d = rem_q;
    res_d = res_q;
    r2    = '0;
    trial = '0;
    case (cmd_q)
      ALU_MUL: begin
        acc_d = {acc_q[AluW-2:0], 1'b0} +
                (y_q[Iters-1] ? {32'd0, x_q[33:0]} : {AluW{1'b0}});
        y_d   = {y_q[Iters-2:0], 1'b0};
      end
      ALU_DIV: begin
        r2    = {rem_q[DenW-1:0], x_q[AluW-1]};
        trial = {1'b0, den_q};
        if (r2 >= trial) begin
          rem_d = r2 - trial;
          res_d = {res_q[Iters-2:0], 1'b1};
        end else begin
          rem_d = r2;
          res_d = {res_q[Iters-2:0], 1'b0};
        end
        x_d = {x_q[AluW-2:0], 1'b0};
      end
      ALU_SQRT: begin
        r2    = {rem_q[DenW-2:0], x_q[AluW-1:AluW-2]};
        trial = {2'b00, res_q, 2'b01};
        if (r2 >= trial) begin
          rem_d = r2 - trial;
          res_d = {res_q[Iters-2:0], 1'b1};
        end else begin
          rem_d = r2;
          res_d = {res_q[Iters-2:0], 1'b0};
        end
        x_d = {x_q[AluW-3:0], 2'b00};
      end
      default: begin
        acc_d = acc_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      cmd_q  <= ALU_MUL;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        cmd_q  <= ctl_i.cmd;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(Iters - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      acc_q <= '0;
      res_q <= '0;
      den_q <= b_i;
      y_q   <= b_i[Iters-1:0];
      case (ctl_i.cmd)
        ALU_MUL: begin
          x_q   <= a_i;
          rem_q <= '0;
        end
        ALU_DIV: begin
          // high part is known to stay below the divisor
          x_q   <= {a_i[31:0], 34'd0};
          rem_q <= {2'b00, a_i[AluW-1:32]};
        end
        default: begin
          x_q   <= {a_i[AluW-3:0], 2'b00};
          rem_q <= '0;
        end
      endcase
    end else if (busy_q) begin
      acc_q <= acc_d;
      x_q   <= x_d;
      y_q   <= y_d;
      rem_q <= rem_d;
      res_q <= res_d;
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign res_o = (cmd_q == ALU_MUL) ? acc_q : {34'd0, res_q};

endmodule

`default_nettype wire

// ----- src/bounding_sphere_accumulator.sv -----
// bounding_sphere_accumulator: running bounding sphere over points, spheres and boxes
// depends on bsa_pkg, bsa_in_if, bsa_out_if and bsa_alu
// from accept to result valid: reset op and first point or sphere go straight to the output;
//   first box runs three squares and a root; point or box runs three squares and the radius
//   square, plus a root if it grows; sphere runs three squares and a root, and a merge adds
//   a multiply and a divide on each axis; one item at a time, next accept in the cycle after
//   the result is loaded, held off while the output register still waits
// reset: center, radius and valid flag clear at once; no clearing pass
`default_nettype none

module bounding_sphere_accumulator import bsa_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  bsa_in_if.sink   in_i,
  bsa_out_if.source out_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PREP  = 4'd1;
  localparam logic [3:0] S_DIFF  = 4'd2;
  localparam logic [3:0] S_SQ    = 4'd3;
  localparam logic [3:0] S_SQW   = 4'd4;
  localparam logic [3:0] S_RSQ   = 4'd5;
  localparam logic [3:0] S_RSQW  = 4'd6;
  localparam logic [3:0] S_SQRT  = 4'd7;
  localparam logic [3:0] S_SQRTW = 4'd8;
  localparam logic [3:0] S_MUL   = 4'd9;
  localparam logic [3:0] S_MULW  = 4'd10;
  localparam logic [3:0] S_DIV   = 4'd11;
  localparam logic [3:0] S_DIVW  = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  logic [3:0] st_q;
  logic [1:0] ax_q;
  logic       valid_q;
  logic       out_valid_q;
  logic signed [CoordW-1:0] mid_q [3];
  logic [SizeW-1:0]         ext_q;

  // captured item and work registers
  logic [1:0]               op_q;
  logic signed [CoordW-1:0] p_q [3];
  logic signed [CoordW-1:0] q_q [3];
  logic [RadW-1:0]          sr_q;
  logic [DiffW-1:0]         d_q [3];
  logic [63:0]              sum_q;
  logic [33:0]              s_q;
  logic [33:0]              w_q;
  logic [AluW-1:0]          prod_q;

  logic signed [CoordW-1:0] oc_q [3];
  logic [SizeW-1:0]         osz_q;
  logic                     ov_q;

  alu_ctl_t        alu_ctl;
  alu_sts_t        alu_sts;
  logic [AluW-1:0] alu_a;
  logic [DenW-1:0] alu_b;
  logic [AluW-1:0] alu_res;

  logic signed [CoordW-1:0] half [3];
  logic [DiffW-1:0]         dnew [3];
  logic [32:0]              grow_sum;
  logic signed [31:0]       merged;

  bsa_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (alu_ctl),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .sts_o  (alu_sts),
    .res_o  (alu_res)
  );

  function automatic logic [DiffW-1:0] abs_diff(logic signed [CoordW-1:0] a,
                                                logic signed [CoordW-1:0] b);
    logic signed [DiffW-1:0] t;
    t = DiffW'(a) - DiffW'(b);
    return t[DiffW-1] ? DiffW'(-t) : DiffW'(t);
  endfunction

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [31:0] sm;
      logic [DiffW-1:0]   dp, dq;
      sm = 32'(p_q[i]) + 32'(q_q[i]);
      half[i] = sm[31:1];
      dp = abs_diff(p_q[i], mid_q[i]);
      dq = abs_diff(q_q[i], mid_q[i]);
      if (!valid_q) begin
        dnew[i] = dq;
      end else if (op_q == OP_BOX) begin
        // farthest corner is the farther bound on each axis
        dnew[i] = (dq > dp) ? dq : dp;
      end else begin
        dnew[i] = dp;
      end
    end
  end

  assign grow_sum = 33'(alu_res[31:0]) + 33'(sr_q);
  assign merged = (p_q[ax_q] >= mid_q[ax_q]) ? 32'(mid_q[ax_q]) + 32'(alu_res[31:0])
                                             : 32'(mid_q[ax_q]) - 32'(alu_res[31:0]);

  always_comb begin
    alu_ctl.start = 1'b0;
    alu_ctl.cmd   = ALU_MUL;
    alu_a         = '0;
    alu_b         = '0;
    case (st_q)
      S_SQ: begin
        alu_ctl.start = 1'b1;
        alu_a = AluW'(d_q[ax_q]);
        alu_b = DenW'(d_q[ax_q]);
      end
      S_RSQ: begin
        alu_ctl.start = 1'b1;
        alu_a = AluW'(ext_q);
        alu_b = DenW'(ext_q);
      end
      S_SQRT: begin
        alu_ctl.start = 1'b1;
        alu_ctl.cmd   = ALU_SQRT;
        alu_a = AluW'(sum_q);
      end
      S_MUL: begin
        alu_ctl.start = 1'b1;
        alu_a = AluW'(w_q);
        alu_b = DenW'(d_q[ax_q]);
      end
      S_DIV: begin
        alu_ctl.start = 1'b1;
        alu_ctl.cmd   = ALU_DIV;
        alu_a = prod_q;
        alu_b = {s_q, 1'b0};
      end
      default: begin
        alu_ctl.start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      ax_q        <= '0;
      valid_q     <= 1'b0;
      out_valid_q <= 1'b0;
      ext_q       <= '0;
      for (int i = 0; i < 3; i++) mid_q[i] <= '0;
    end else begin
      if (st_q == S_OUT && (!out_valid_q || out_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (st_q)
        S_IDLE: begin
          if (in_i.valid) st_q <= S_PREP;
        end
        S_PREP: begin
          if (op_q == OP_RESET) begin
            for (int i = 0; i < 3; i++) mid_q[i] <= '0;
            ext_q   <= '0;
            valid_q <= 1'b0;
            st_q    <= S_OUT;
          end else if (!valid_q && op_q == OP_BOX) begin
            for (int i = 0; i < 3; i++) mid_q[i] <= half[i];
            st_q <= S_DIFF;
          end else if (!valid_q) begin
            for (int i = 0; i < 3; i++) mid_q[i] <= p_q[i];
            ext_q   <= (op_q == OP_SPHERE) ? SizeW'(sr_q) : '0;
            valid_q <= 1'b1;
            st_q    <= S_OUT;
          end else begin
            st_q <= S_DIFF;
          end
        end
        S_DIFF: begin
          ax_q <= '0;
          st_q <= S_SQ;
        end
        S_SQ: st_q <= S_SQW;
        S_SQW: begin
          if (alu_sts.done) begin
            if (ax_q == 2'd2) begin
              if (!valid_q || op_q == OP_SPHERE) st_q <= S_SQRT;
              else st_q <= S_RSQ;
            end else begin
              ax_q <= ax_q + 1'b1;
              st_q <= S_SQ;
            end
          end
        end
        S_RSQ: st_q <= S_RSQW;
        S_RSQW: begin
          if (alu_sts.done) st_q <= (sum_q > alu_res[63:0]) ? S_SQRT : S_OUT;
        end
        S_SQRT: st_q <= S_SQRTW;
        S_SQRTW: begin
          if (alu_sts.done) begin
            if (!valid_q || op_q != OP_SPHERE) begin
              ext_q   <= alu_res[SizeW-1:0];
              valid_q <= 1'b1;
              st_q    <= S_OUT;
            end else if (grow_sum > 33'(ext_q)) begin
              ax_q <= '0;
              st_q <= S_MUL;
            end else begin
              st_q <= S_OUT;
            end
          end
        end
        S_MUL: st_q <= S_MULW;
        S_MULW: begin
          if (alu_sts.done) st_q <= S_DIV;
        end
        S_DIV: st_q <= S_DIVW;
        S_DIVW: begin
          if (alu_sts.done) begin
            mid_q[ax_q] <= merged[CoordW-1:0];
            if (ax_q == 2'd2) begin
              // half the merged span, saturated
              ext_q <= s_q[33] ? {SizeW{1'b1}} : s_q[32:1];
              st_q  <= S_OUT;
            end else begin
              ax_q <= ax_q + 1'b1;
              st_q <= S_MUL;
            end
          end
        end
        S_OUT: begin
          if (!out_valid_q || out_o.ready) st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      S_IDLE: begin
        if (in_i.valid) begin
          op_q   <= in_i.op;
          p_q[0] <= in_i.pos_x;
          p_q[1] <= in_i.pos_y;
          p_q[2] <= in_i.pos_z;
          q_q[0] <= in_i.box_max_x;
          q_q[1] <= in_i.box_max_y;
          q_q[2] <= in_i.box_max_z;
          sr_q   <= in_i.sphere_radius;
        end
      end
      S_DIFF: begin
        for (int i = 0; i < 3; i++) d_q[i] <= dnew[i];
        sum_q <= '0;
      end
      S_SQW: begin
        if (alu_sts.done) sum_q <= sum_q + alu_res[63:0];
      end
      S_SQRTW: begin
        if (alu_sts.done) begin
          s_q <= 34'(ext_q) + 34'(sr_q) + 34'(alu_res[31:0]);
          w_q <= {3'b000, sr_q, 1'b0} + 34'(alu_res[31:0]);
        end
      end
      S_MULW: begin
        if (alu_sts.done) prod_q <= alu_res;
      end
      S_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          for (int i = 0; i < 3; i++) oc_q[i] <= mid_q[i];
          osz_q <= ext_q;
          ov_q  <= valid_q;
        end
      end
      default: begin
        prod_q <= prod_q;
      end
    endcase
  end

  assign in_i.ready        = (st_q == S_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.center_x    = oc_q[0];
  assign out_o.center_y    = oc_q[1];
  assign out_o.center_z    = oc_q[2];
  assign out_o.sphere_size = osz_q;
  assign out_o.is_valid    = ov_q;

  // the serial unit is never mid-operation while a new item can enter
  a_idle_alu: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_IDLE) |-> !alu_sts.busy)
    else $error("serial unit busy while taking a new item");

  // an invalid sphere at rest carries zero radius and center; the check covers center x
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_IDLE && !valid_q) |-> (ext_q == '0 && mid_q[0] == '0))
    else $error("invalid sphere with nonzero state");

  // unit results only arrive while the sequencer waits for them
  a_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_sts.done |-> (st_q == S_SQW || st_q == S_RSQW || st_q == S_SQRTW ||
                      st_q == S_MULW || st_q == S_DIVW))
    else $error("serial result with no waiting state");

endmodule

`default_nettype wire

// ----- dv/bounding_sphere_accumulator_test.sv -----
// bounding_sphere_accumulator_test: self-checking bench for the running bounding sphere block
// depends on bsa_pkg, bsa_in_if, bsa_out_if and the block itself
`timescale 1ns / 1ps

module bounding_sphere_accumulator_test;
  import bsa_pkg::*;

  localparam int unsigned NumRandom  = 2000;
  localparam int unsigned CycleLimit = 4000000;
  localparam int unsigned TailCycles = 400;
  localparam logic [63:0] SizeMax    = 64'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]               op;
    logic signed [CoordW-1:0] px;
    logic signed [CoordW-1:0] py;
    logic signed [CoordW-1:0] pz;
    logic [RadW-1:0]          rad;
    logic signed [CoordW-1:0] qx;
    logic signed [CoordW-1:0] qy;
    logic signed [CoordW-1:0] qz;
  } prim_t;

  typedef struct packed {
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic signed [CoordW-1:0] cz;
    logic [SizeW-1:0]         size;
    logic                     vld;
  } sphere_t;

  typedef struct {
    prim_t   prim;
    bit      known;
    sphere_t sph;
  } vector_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  bsa_in_if  in_ch ();
  bsa_out_if out_ch ();

  bounding_sphere_accumulator DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor state
  longint    ctr_x, ctr_y, ctr_z;
  longint    rad_q;
  bit        occupied;
  sphere_t   sphere_q[$];
  int        errors = 0;
  int        cycles = 0;
  int        send_idle = 22;
  int        recv_idle = 85;
  vector_t   vectors[$];

  function automatic longint unsigned udiff(longint a, longint b);
    return (a >= b) ? longint'(a - b) : longint'(b - a);
  endfunction

  function automatic longint unsigned sqdist(longint ax, longint ay, longint az,
                                             longint bx, longint by, longint bz);
    longint unsigned dx, dy, dz, s, t;
    dx = udiff(ax, bx);
    dy = udiff(ay, by);
    dz = udiff(az, bz);
    s = dx * dx + dy * dy;
    if (s < dx * dx) s = '1;
    t = s + dz * dz;
    if (t < s) t = '1;
    return t;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned clamp_size(longint unsigned v);
    return (v > SizeMax) ? SizeMax : v;
  endfunction

  function automatic longint pull_toward(longint c, longint p, longint unsigned w,
                                         longint unsigned den);
    longint unsigned q;
    q = (w * udiff(p, c)) / den;
    return (p >= c) ? c + longint'(q) : c - longint'(q);
  endfunction

  function automatic void grow_radius(longint unsigned d2);
    longint unsigned r;
    r = rad_q;
    if (d2 > r * r) rad_q = clamp_size(int_sqrt(d2));
  endfunction

  function automatic sphere_t include_prim(prim_t p);
    longint px, py, pz, qx, qy, qz, cx, cy, cz;
    longint unsigned best, d2, gap, s, w, sr;
    sphere_t r;
    px = p.px; py = p.py; pz = p.pz;
    qx = p.qx; qy = p.qy; qz = p.qz;
    sr = p.rad;
    if (p.op == OP_RESET) begin
      ctr_x = 0; ctr_y = 0; ctr_z = 0; rad_q = 0; occupied = 0;
    end else if (!occupied) begin
      if (p.op == OP_POINT) begin
        ctr_x = px; ctr_y = py; ctr_z = pz; rad_q = 0;
      end else if (p.op == OP_SPHERE) begin
        ctr_x = px; ctr_y = py; ctr_z = pz; rad_q = sr;
      end else begin
        // arithmetic shift is floor division by two
        ctr_x = (px + qx) >>> 1;
        ctr_y = (py + qy) >>> 1;
        ctr_z = (pz + qz) >>> 1;
        rad_q = clamp_size(int_sqrt(sqdist(qx, qy, qz, ctr_x, ctr_y, ctr_z)));
      end
      occupied = 1;
    end else if (p.op == OP_POINT) begin
      grow_radius(sqdist(px, py, pz, ctr_x, ctr_y, ctr_z));
    end else if (p.op == OP_BOX) begin
      best = 0;
      for (int k = 0; k < 8; k++) begin
        cx = k[0] ? qx : px;
        cy = k[1] ? qy : py;
        cz = k[2] ? qz : pz;
        d2 = sqdist(cx, cy, cz, ctr_x, ctr_y, ctr_z);
        if (d2 > best) best = d2;
      end
      grow_radius(best);
    end else begin
      gap = int_sqrt(sqdist(px, py, pz, ctr_x, ctr_y, ctr_z));
      if (gap + sr > longint'(rad_q)) begin
        s = rad_q + sr + gap;
        w = 2 * sr + gap;
        ctr_x = pull_toward(ctr_x, px, w, 2 * s);
        ctr_y = pull_toward(ctr_y, py, w, 2 * s);
        ctr_z = pull_toward(ctr_z, pz, w, 2 * s);
        rad_q = clamp_size(s / 2);
      end
    end
    r.cx = ctr_x[CoordW-1:0];
    r.cy = ctr_y[CoordW-1:0];
    r.cz = ctr_z[CoordW-1:0];
    r.size = rad_q[SizeW-1:0];
    r.vld = occupied;
    return r;
  endfunction

  function automatic logic signed [CoordW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return {1'b1, {(CoordW-1){1'b0}}};
      1: return {1'b0, {(CoordW-1){1'b1}}};
      2, 3: return $signed(CoordW'($urandom_range(0, 32'h0020_0000))) - 31'sh0010_0000;
      default: return CoordW'($urandom);
    endcase
  endfunction

  function automatic prim_t rand_prim();
    prim_t p;
    int sel;
    sel = $urandom_range(0, 99);
    p.op = (sel < 30) ? OP_POINT : (sel < 60) ? OP_SPHERE : (sel < 93) ? OP_BOX : OP_RESET;
    p.px = rand_coord(); p.py = rand_coord(); p.pz = rand_coord();
    p.qx = rand_coord(); p.qy = rand_coord(); p.qz = rand_coord();
    case ($urandom_range(0, 3))
      0: p.rad = {RadW{1'b1}};
      1: p.rad = RadW'($urandom_range(0, 32'h0010_0000));
      default: p.rad = RadW'($urandom);
    endcase
    return p;
  endfunction

  function automatic prim_t mk(logic [1:0] op, int px, int py, int pz, int rad,
                               int qx, int qy, int qz);
    prim_t p;
    p.op = op; p.px = CoordW'(px); p.py = CoordW'(py); p.pz = CoordW'(pz);
    p.rad = RadW'(rad);
    p.qx = CoordW'(qx); p.qy = CoordW'(qy); p.qz = CoordW'(qz);
    return p;
  endfunction

  function automatic void add_row(prim_t p, bit known, sphere_t s);
    vector_t v;
    v.prim = p; v.known = known; v.sph = s;
    vectors.push_back(v);
  endfunction

  function automatic void build_table();
    int mn, mx;
    sphere_t z;
    mn = -32'sd1073741824;
    mx = 32'sd1073741823;
    z = '0;
    add_row(mk(OP_RESET, mx, mx, mx, 1234, mx, mx, mx), 1, z);
    add_row(mk(OP_POINT, 100, -200, 300, 0, 0, 0, 0), 1,
            '{31'sd100, -31'sd200, 31'sd300, 32'd0, 1'b1});
    add_row(mk(OP_POINT, mx, mx, mx, 0, 0, 0, 0), 0, z);
    add_row(mk(OP_POINT, mn, mn, mn, 0, 0, 0, 0), 0, z);
    add_row(mk(OP_RESET, 0, 0, 0, 0, 0, 0, 0), 1, z);
    add_row(mk(OP_SPHERE, mn, mx, 0, 32'h3FFF_FFFF, 0, 0, 0), 1,
            '{CoordW'(mn), CoordW'(mx), 31'sd0, 32'h3FFF_FFFF, 1'b1});
    add_row(mk(OP_SPHERE, mx, mn, mx, 32'h3FFF_FFFF, 0, 0, 0), 0, z);
    add_row(mk(OP_SPHERE, 0, 0, 0, 0, 0, 0, 0), 0, z);
    add_row(mk(OP_RESET, 0, 0, 0, 0, 0, 0, 0), 1, z);
    add_row(mk(OP_BOX, mn, mn, mn, 0, mx, mx, mx), 0, z);
    add_row(mk(OP_BOX, -5, -5, -5, 0, 5, 5, 5), 0, z);
    add_row(mk(OP_RESET, 0, 0, 0, 0, 0, 0, 0), 1, z);
    // inverted box, maximum below minimum
    add_row(mk(OP_BOX, 1000, 2000, 3000, 0, -1000, -2001, 7), 0, z);
    add_row(mk(OP_BOX, mx, mn, mx, 0, mn, mx, mn), 0, z);
    // contained sphere still runs the merge test
    add_row(mk(OP_SPHERE, 0, 0, 0, 1, 0, 0, 0), 0, z);
    add_row(mk(OP_SPHERE, 40000, -40000, 65536, 300000, 0, 0, 0), 0, z);
    add_row(mk(OP_POINT, 0, 0, 0, 0, 0, 0, 0), 0, z);
    add_row(mk(OP_RESET, 0, 0, 0, 0, 0, 0, 0), 1, z);
    add_row(mk(OP_BOX, 7, 7, 7, 0, 7, 7, 7), 1, '{31'sd7, 31'sd7, 31'sd7, 32'd0, 1'b1});
  endfunction

  // valid stays high across back-to-back items and drops only while idling
  task automatic send_prim(prim_t p, bit known, sphere_t s);
    sphere_t e;
    while ($urandom_range(0, 99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= p.op;
    in_ch.pos_x <= p.px; in_ch.pos_y <= p.py; in_ch.pos_z <= p.pz;
    in_ch.sphere_radius <= p.rad;
    in_ch.box_max_x <= p.qx; in_ch.box_max_y <= p.qy; in_ch.box_max_z <= p.qz;
    do @(posedge clk_i); while (!in_ch.ready);
    e = include_prim(p);
    if (known && e != s) begin
      $display("%0t table row mismatch: table %h predictor %h", $time, s, e);
      errors++;
    end
    sphere_q.push_back(known ? s : e);
    @(negedge clk_i);
  endtask

  // receiver side: random stall, check every transfer
  always @(negedge clk_i) begin
    if (rst_ni) out_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  always @(posedge clk_i) begin
    sphere_t got, want;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.center_x, out_ch.center_y, out_ch.center_z,
              out_ch.sphere_size, out_ch.is_valid};
      if (sphere_q.size() == 0) begin
        $display("%0t unexpected result %h", $time, got);
        errors++;
      end else begin
        want = sphere_q.pop_front();
        if (got.cx !== want.cx)
          $display("%0t center_x exp %h got %h", $time, want.cx, got.cx);
        if (got.cy !== want.cy)
          $display("%0t center_y exp %h got %h", $time, want.cy, got.cy);
        if (got.cz !== want.cz)
          $display("%0t center_z exp %h got %h", $time, want.cz, got.cz);
        if (got.size !== want.size)
          $display("%0t sphere_size exp %h got %h", $time, want.size, got.size);
        if (got.vld !== want.vld)
          $display("%0t is_valid exp %b got %b", $time, want.vld, got.vld);
        if (got !== want) errors++;
      end
    end
  end

  initial begin
    sphere_t none;
    none = '0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_POINT;
    in_ch.pos_x = '0; in_ch.pos_y = '0; in_ch.pos_z = '0;
    in_ch.sphere_radius = '0;
    in_ch.box_max_x = '0; in_ch.box_max_y = '0; in_ch.box_max_z = '0;
    out_ch.ready = 1'b0;
    ctr_x = 0; ctr_y = 0; ctr_z = 0; rad_q = 0; occupied = 0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    build_table();
    foreach (vectors[i]) send_prim(vectors[i].prim, vectors[i].known, vectors[i].sph);
    for (int n = 0; n < NumRandom; n++) begin
      if (n == NumRandom / 3) begin
        send_idle = 85; recv_idle = 22;
      end else if (n == 2 * NumRandom / 3) begin
        send_idle = 0; recv_idle = 0;
      end
      // hold off until the block has drained
      if (n == NumRandom / 2) begin
        in_ch.valid <= 1'b0;
        wait (sphere_q.size() == 0);
        @(negedge clk_i);
      end
      send_prim(rand_prim(), 0, none);
    end
    in_ch.valid <= 1'b0;
    wait (sphere_q.size() == 0);
    repeat (TailCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
